FILE: design/tlof_pkg.sv
// types and constants shared by the top level operator finder
// no dependencies; compiled first

package tlof_pkg;

    // character codes that steer the context tracking
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_POPEN  = 8'h28;
    localparam logic [7:0] CH_PCLOSE = 8'h29;
    localparam logic [7:0] CH_SOPEN  = 8'h5B;
    localparam logic [7:0] CH_SCLOSE = 8'h5D;

    // configuration register indexes
    localparam logic [2:0] CFG_FIRST  = 3'd0;
    localparam logic [2:0] CFG_SECOND = 3'd1;
    localparam logic [2:0] CFG_THIRD  = 3'd2;
    localparam logic [2:0] CFG_LENGTH = 3'd3;
    localparam logic [2:0] CFG_LAST   = 3'd4;

    // configuration reset values
    localparam logic [7:0] RST_FIRST  = 8'd61;
    localparam logic [1:0] RST_LENGTH = 2'd1;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_STRAY_CLOSE = 2'd1;
    localparam logic [1:0] ST_OPEN_SQUARE = 2'd2;
    localparam logic [1:0] ST_OPEN_QUOTE  = 2'd3;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_QUOTE,
        CLS_BSLASH,
        CLS_EQ,
        CLS_POPEN,
        CLS_PCLOSE,
        CLS_SOPEN,
        CLS_SCLOSE
    } t_cls;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_char;

    typedef struct packed {
        logic        found;
        logic [15:0] position;
        logic [1:0]  status;
    } t_result;

    // classified character as it sits in the queue
    typedef struct packed {
        t_cls cls;
        logic hit_first;
        logic hit_second;
        logic hit_third;
        logic last_char;
    } t_item;

    typedef struct packed {
        logic [1:0] op_length;
        logic       find_last;
        logic       first_is_eq;
    } t_cfg;

endpackage

FILE: design/tlof_if.sv
// valid/ready channel carrying one payload of type t_payload
// no dependencies

interface tlof_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/tlof_front.sv
// front end: configuration registers and character classification
// depends on tlof_pkg and tlof_if

module tlof_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    tlof_if.sink              i_char,
    tlof_if.source            o_item,
    output tlof_pkg::t_cfg    o_cfg
);
    import tlof_pkg::*;

    logic [7:0] r_first;
    logic [7:0] r_second;
    logic [7:0] r_third;
    logic [1:0] r_length;
    logic       r_find_last;
    t_cls       w_cls;
    logic [7:0] w_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= RST_FIRST;
            r_second    <= '0;
            r_third     <= '0;
            r_length    <= RST_LENGTH;
            r_find_last <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST:  r_first     <= i_cfg_data;
                CFG_SECOND: r_second    <= i_cfg_data;
                CFG_THIRD:  r_third     <= i_cfg_data;
                CFG_LENGTH: r_length    <= i_cfg_data[1:0];
                CFG_LAST:   r_find_last <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_c = i_char.data.char_code;

    always_comb begin
        case (w_c)
            CH_QUOTE:  w_cls = CLS_QUOTE;
            CH_BSLASH: w_cls = CLS_BSLASH;
            CH_EQ:     w_cls = CLS_EQ;
            CH_POPEN:  w_cls = CLS_POPEN;
            CH_PCLOSE: w_cls = CLS_PCLOSE;
            CH_SOPEN:  w_cls = CLS_SOPEN;
            CH_SCLOSE: w_cls = CLS_SCLOSE;
            default:   w_cls = CLS_OTHER;
        endcase
    end

    assign o_item.valid           = i_char.valid;
    assign i_char.ready           = o_item.ready;
    assign o_item.data.cls        = w_cls;
    assign o_item.data.hit_first  = (w_c == r_first);
    assign o_item.data.hit_second = (w_c == r_second);
    assign o_item.data.hit_third  = (w_c == r_third);
    assign o_item.data.last_char  = i_char.data.last_char;

    assign o_cfg.op_length   = r_length;
    assign o_cfg.find_last   = r_find_last;
    assign o_cfg.first_is_eq = (r_first == CH_EQ);

endmodule

FILE: design/tlof_queue.sv
// short fifo of classified characters between front and back
// depends on tlof_pkg and tlof_if

module tlof_queue (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tlof_if.sink   i_push,
    tlof_if.source o_pop
);
    import tlof_pkg::*;

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_CW-1:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign i_push.ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.data   = r_mem[r_rd];
    assign w_push       = i_push.valid && i_push.ready;
    assign w_pop        = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: design/tlof_back.sv
// back end: depth and quote tracking, operator candidates, result register
// depends on tlof_pkg and tlof_if

module tlof_back #(
    parameter int MAX_OP_LEN  = 3,
    parameter int INDEX_WIDTH = 16,
    parameter int DEPTH_WIDTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlof_pkg::t_cfg i_cfg,
    tlof_if.sink           i_item,
    tlof_if.source         o_result
);
    import tlof_pkg::*;

    localparam int         LEN_LIM = (MAX_OP_LEN > 3) ? 3 : MAX_OP_LEN;
    localparam logic [1:0] LEN_CAP = 2'(LEN_LIM);

    logic [DEPTH_WIDTH-1:0] r_paren, n_paren;
    logic [DEPTH_WIDTH-1:0] r_brack, n_brack;
    logic                   r_quote, n_quote;
    logic                   r_prev_bslash;
    logic                   r_prev_eq;
    logic [INDEX_WIDTH-1:0] r_index;
    logic [1:0]             r_prog [MAX_OP_LEN];
    logic [1:0]             n_prog [MAX_OP_LEN];
    logic [INDEX_WIDTH-1:0] r_start [MAX_OP_LEN];
    logic [INDEX_WIDTH-1:0] n_start [MAX_OP_LEN];
    logic [INDEX_WIDTH-1:0] r_best, n_best;
    logic                   r_seen, n_seen;
    logic [1:0]             r_err, n_err;
    logic                   r_out_valid;
    t_result                r_out;

    logic [1:0] w_len;
    logic       w_elig;
    logic       w_placed;
    logic       w_eq_mode;
    logic       w_hit;
    logic       w_pop;
    t_item      w_it;

    assign w_it = i_item.data;

    always_comb begin
        if (i_cfg.op_length == 2'd0) begin
            w_len = 2'd1;
        end else if (i_cfg.op_length > LEN_CAP) begin
            w_len = LEN_CAP;
        end else begin
            w_len = i_cfg.op_length;
        end
    end

    assign w_eq_mode = (w_len == 2'd1) && i_cfg.first_is_eq;

    always_comb begin
        n_prog   = r_prog;
        n_start  = r_start;
        n_seen   = r_seen;
        n_best   = r_best;
        n_err    = r_err;
        n_paren  = r_paren;
        n_brack  = r_brack;
        n_quote  = r_quote;
        w_elig   = 1'b0;
        w_placed = 1'b0;
        w_hit    = 1'b0;

        // advance candidates in progress
        for (int k = 0; k < MAX_OP_LEN; k++) begin
            if (r_prog[k] != 2'd0) begin
                n_prog[k] = 2'd0;
                w_hit = (r_prog[k] == 2'd1) ? w_it.hit_second : w_it.hit_third;
                if (w_len == 2'd1) begin
                    if (w_it.cls != CLS_EQ && n_err == ST_OK
                        && (i_cfg.find_last || !n_seen)) begin
                        n_seen = 1'b1;
                        n_best = r_start[k];
                    end
                end else if (r_prog[k] < w_len && w_hit) begin
                    if (r_prog[k] + 2'd1 == w_len) begin
                        if (n_err == ST_OK && (i_cfg.find_last || !n_seen)) begin
                            n_seen = 1'b1;
                            n_best = r_start[k];
                        end
                    end else begin
                        n_prog[k] = r_prog[k] + 2'd1;
                    end
                end
            end
        end

        // context tracking
        if (r_quote) begin
            if (w_it.cls == CLS_QUOTE && !r_prev_bslash) begin
                n_quote = 1'b0;
            end
        end else if (r_brack != '0) begin
            if (w_it.cls == CLS_SOPEN) begin
                if (r_brack != '1) begin
                    n_brack = r_brack + 1'b1;
                end
            end else if (w_it.cls == CLS_SCLOSE) begin
                n_brack = r_brack - 1'b1;
                w_elig  = (n_brack == '0) && (r_paren == '0);
            end
        end else begin
            case (w_it.cls)
                CLS_POPEN: begin
                    if (r_paren != '1) begin
                        n_paren = r_paren + 1'b1;
                    end
                end
                CLS_PCLOSE: begin
                    if (r_paren == '0) begin
                        if (i_cfg.find_last || !n_seen) begin
                            if (n_err == ST_OK) begin
                                n_err = ST_STRAY_CLOSE;
                            end
                            n_seen = 1'b0;
                            n_best = '0;
                            for (int k = 0; k < MAX_OP_LEN; k++) begin
                                n_prog[k] = 2'd0;
                            end
                        end
                    end else begin
                        n_paren = r_paren - 1'b1;
                        w_elig  = (n_paren == '0);
                    end
                end
                CLS_SOPEN: n_brack = DEPTH_WIDTH'(1);
                CLS_QUOTE: n_quote = 1'b1;
                default:   w_elig  = (r_paren == '0);
            endcase
        end

        // start a new candidate
        if (w_elig && w_it.hit_first && n_err == ST_OK) begin
            if (w_len == 2'd1 && !w_eq_mode) begin
                if (i_cfg.find_last || !n_seen) begin
                    n_seen = 1'b1;
                    n_best = r_index;
                end
            end else if (!(w_eq_mode && r_prev_eq)) begin
                for (int k = 0; k < MAX_OP_LEN; k++) begin
                    if (!w_placed && n_prog[k] == 2'd0) begin
                        w_placed   = 1'b1;
                        n_prog[k]  = 2'd1;
                        n_start[k] = r_index;
                    end
                end
            end
        end

        // end of expression: a pending lone '=' is accepted; an open quote or bracket sets its status
        if (w_it.last_char) begin
            for (int k = 0; k < MAX_OP_LEN; k++) begin
                if (n_prog[k] != 2'd0 && w_len == 2'd1 && n_err == ST_OK
                    && (i_cfg.find_last || !n_seen)) begin
                    n_seen = 1'b1;
                    n_best = n_start[k];
                end
            end
            if (n_quote || n_brack != '0) begin
                if (i_cfg.find_last || !n_seen) begin
                    if (n_err == ST_OK) begin
                        n_err = n_quote ? ST_OPEN_QUOTE : ST_OPEN_SQUARE;
                    end
                    n_seen = 1'b0;
                    n_best = '0;
                end
            end
        end
    end

    assign i_item.ready  = !w_it.last_char || !r_out_valid || o_result.ready;
    assign w_pop         = i_item.valid && i_item.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paren       <= '0;
            r_brack       <= '0;
            r_quote       <= 1'b0;
            r_prev_bslash <= 1'b0;
            r_prev_eq     <= 1'b0;
            r_index       <= '0;
            r_best        <= '0;
            r_seen        <= 1'b0;
            r_err         <= ST_OK;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < MAX_OP_LEN; k++) begin
                r_prog[k]  <= 2'd0;
                r_start[k] <= '0;
            end
        end else begin
            if (w_pop && w_it.last_char) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_pop) begin
                if (w_it.last_char) begin
                    r_paren       <= '0;
                    r_brack       <= '0;
                    r_quote       <= 1'b0;
                    r_prev_bslash <= 1'b0;
                    r_prev_eq     <= 1'b0;
                    r_index       <= '0;
                    r_best        <= '0;
                    r_seen        <= 1'b0;
                    r_err         <= ST_OK;
                    for (int k = 0; k < MAX_OP_LEN; k++) begin
                        r_prog[k]  <= 2'd0;
                        r_start[k] <= '0;
                    end
                end else begin
                    r_paren       <= n_paren;
                    r_brack       <= n_brack;
                    r_quote       <= n_quote;
                    r_prev_bslash <= (w_it.cls == CLS_BSLASH);
                    r_prev_eq     <= (w_it.cls == CLS_EQ);
                    if (r_index != '1) begin
                        r_index <= r_index + 1'b1;
                    end
                    r_best <= n_best;
                    r_seen <= n_seen;
                    r_err  <= n_err;
                    r_prog  <= n_prog;
                    r_start <= n_start;
                end
            end
        end
    end

    // result register, no reset needed on payload
    always_ff @(posedge i_clk) begin
        if (w_pop && w_it.last_char) begin
            r_out.found    <= n_seen;
            r_out.position <= n_seen ? 16'(n_best) : 16'd0;
            r_out.status   <= n_err;
        end
    end

endmodule

FILE: design/top_level_operator_finder_unit.sv
// top level of the operator finder: front, queue and back
// depends on tlof_pkg, tlof_if, tlof_front, tlof_queue and tlof_back
//
// path: the final character is held in the queue, then the back end loads
//   the result into its output register, which drives the result channel
// throughput: one character per cycle through the back end;
//   the back stalls only when a finished result has not been taken yet
// reset (synchronous, active low): configuration returns to its reset values,
//   the queue empties and all per-expression tracking state clears

module top_level_operator_finder_unit #(
    parameter int MAX_OP_LEN  = 3,
    parameter int INDEX_WIDTH = 16,
    parameter int DEPTH_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    tlof_if.sink       i_char,
    tlof_if.source     o_result
);
    import tlof_pkg::*;

    // configuration seen by the back end
    t_cfg w_cfg;

    // classified characters into and out of the queue
    tlof_if #(.t_payload(t_item)) w_front_q ();
    tlof_if #(.t_payload(t_item)) w_q_back ();

    // front: holds the operator registers and tags each character
    tlof_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (i_char),
        .o_item      (w_front_q),
        .o_cfg       (w_cfg)
    );

    // queue: decouples the input side from result stalls
    tlof_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_q),
        .o_pop   (w_q_back)
    );

    // back: depth, quote and candidate tracking plus the result register
    tlof_back #(
        .MAX_OP_LEN  (MAX_OP_LEN),
        .INDEX_WIDTH (INDEX_WIDTH),
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (w_q_back),
        .o_result (o_result)
    );

endmodule

FILE: tb/testbench.sv
// testbench for the top level operator finder: streams expressions, predicts each result
// depends on tlof_pkg, tlof_if and top_level_operator_finder_unit

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tlof_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    // extra wait for the pipeline to empty after the last awaited result
    localparam int DRAIN_CYCLES = 6;
    localparam int END_WAIT_LIMIT = 4000;
    localparam int DEEP_NEST = 256;

    // predicts found, position and status for every expression and checks the block
    class match_tracker;
        logic [7:0]  op_code[3];
        logic [1:0]  op_len_reg;
        logic        last_mode;
        logic [7:0]  paren_lvl;
        logic [7:0]  square_lvl;
        logic        in_str;
        logic [7:0]  prev_code;
        logic [15:0] char_pos;
        logic [1:0]  part_len[3];
        logic [15:0] part_start[3];
        logic [15:0] best_pos;
        logic        have_match;
        logic [1:0]  fault;
        t_result     awaited_matches[$];
        int          mismatches;

        function new();
            op_code[0] = RST_FIRST;
            op_code[1] = 8'd0;
            op_code[2] = 8'd0;
            op_len_reg = RST_LENGTH;
            last_mode = 1'b0;
            mismatches = 0;
            clear_expr();
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                CFG_FIRST: op_code[0] = val;
                CFG_SECOND: op_code[1] = val;
                CFG_THIRD: op_code[2] = val;
                CFG_LENGTH: op_len_reg = val[1:0];
                CFG_LAST: last_mode = val[0];
                default: ;
            endcase
        endfunction

        // length zero acts as one; the two-bit register cannot exceed three
        function int op_size();
            return (op_len_reg == 2'd0) ? 1 : int'(op_len_reg);
        endfunction

        function void clear_parts();
            for (int k = 0; k < 3; k++) begin
                part_len[k] = 2'd0;
                part_start[k] = 16'd0;
            end
        endfunction

        function void clear_expr();
            paren_lvl = 8'd0;
            square_lvl = 8'd0;
            in_str = 1'b0;
            prev_code = 8'd0;
            char_pos = 16'd0;
            best_pos = 16'd0;
            have_match = 1'b0;
            fault = ST_OK;
            clear_parts();
        endfunction

        function void confirm(logic [15:0] s);
            if (fault != ST_OK) return;
            if (last_mode || !have_match) begin
                have_match = 1'b1;
                best_pos = s;
            end
        endfunction

        function void raise_fault(logic [1:0] code);
            if (!last_mode && have_match) return;
            if (fault == ST_OK) fault = code;
            have_match = 1'b0;
            best_pos = 16'd0;
            clear_parts();
        endfunction

        // accepted character transaction: update the context and maybe owe a result
        function void take_char(t_char ch);
            logic [7:0] c;
            logic       eligible;
            logic       eq_mode;
            int         len;
            int         p;
            t_result    want;
            c = ch.char_code;
            len = op_size();
            eligible = 1'b0;

            // partial matches move on or die
            for (int k = 0; k < 3; k++) begin
                p = part_len[k];
                if (p == 0) continue;
                part_len[k] = 2'd0;
                if (len == 1) begin
                    if (c != CH_EQ) confirm(part_start[k]);
                end else if (p < len && c == op_code[p]) begin
                    if (p + 1 == len) confirm(part_start[k]);
                    else part_len[k] = 2'(p + 1);
                end
            end

            // nesting and quoting
            if (in_str) begin
                if (c == CH_QUOTE && prev_code != CH_BSLASH) in_str = 1'b0;
            end else if (square_lvl != 8'd0) begin
                if (c == CH_SOPEN) begin
                    if (square_lvl != 8'hFF) square_lvl++;
                end else if (c == CH_SCLOSE) begin
                    square_lvl--;
                    eligible = (square_lvl == 8'd0 && paren_lvl == 8'd0);
                end
            end else if (c == CH_POPEN) begin
                if (paren_lvl != 8'hFF) paren_lvl++;
            end else if (c == CH_PCLOSE) begin
                if (paren_lvl == 8'd0) begin
                    raise_fault(ST_STRAY_CLOSE);
                end else begin
                    paren_lvl--;
                    eligible = (paren_lvl == 8'd0);
                end
            end else if (c == CH_SOPEN) begin
                square_lvl = 8'd1;
            end else if (c == CH_QUOTE) begin
                in_str = 1'b1;
            end else begin
                eligible = (paren_lvl == 8'd0);
            end

            // a new start; a lone '=' waits one character to see its neighbor
            if (eligible && c == op_code[0] && fault == ST_OK) begin
                eq_mode = (len == 1 && op_code[0] == CH_EQ);
                if (len == 1 && !eq_mode) begin
                    confirm(char_pos);
                end else if (!(eq_mode && prev_code == CH_EQ)) begin
                    for (int k = 0; k < 3; k++) begin
                        if (part_len[k] == 2'd0) begin
                            part_len[k] = 2'd1;
                            part_start[k] = char_pos;
                            break;
                        end
                    end
                end
            end

            if (!ch.last_char) begin
                prev_code = c;
                if (char_pos != 16'hFFFF) char_pos++;
                return;
            end

            // end of expression: only a pending lone '=' still counts
            for (int k = 0; k < 3; k++) begin
                if (part_len[k] != 2'd0 && len == 1) confirm(part_start[k]);
                part_len[k] = 2'd0;
            end
            if (in_str) raise_fault(ST_OPEN_QUOTE);
            else if (square_lvl != 8'd0) raise_fault(ST_OPEN_SQUARE);

            want.found = have_match;
            want.position = have_match ? best_pos : 16'd0;
            want.status = fault;
            awaited_matches.push_back(want);
            clear_expr();
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        // accepted result transaction against the oldest prediction
        task check_match(t_result got);
            t_result want;
            if (awaited_matches.size() == 0) begin
                report("result with none awaited, position", got.position, 0);
                return;
            end
            want = awaited_matches.pop_front();
            if (got.found != want.found) report("found", got.found, want.found);
            if (got.position != want.position)
                report("position", got.position, want.position);
            if (got.status != want.status) report("status", got.status, want.status);
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    tlof_if #(.t_payload(t_char))   char_ch ();
    tlof_if #(.t_payload(t_result)) result_ch ();

    top_level_operator_finder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (char_ch.sink),
        .o_result    (result_ch.source)
    );

    match_tracker tracker;
    logic [7:0]   expr_chars[$];
    int           send_pause_pct;
    int           take_pause_pct;
    int           hold_left = 0;
    int           random_items;

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // gaps: mostly short, a few long
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: check every accepted transaction, then decide on a stall
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) tracker.check_match(result_ch.data);
        if (hold_left != 0) begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < take_pause_pct) hold_left = pause_len();
        end
    end

    // one character transaction; valid stays high for a following one
    task automatic send_char(input logic [7:0] code, input logic is_last);
        t_char ch;
        int    gap;
        ch.char_code = code;
        ch.last_char = is_last;
        gap = ($urandom_range(0, 99) < send_pause_pct) ? pause_len() : 0;
        if (gap != 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.data <= ch;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        tracker.take_char(ch);
    endtask

    // close = 0 leaves the expression open for a later part
    task automatic send_expr(input bit close);
        for (int i = 0; i < expr_chars.size(); i++)
            send_char(expr_chars[i], close && (i == expr_chars.size() - 1));
    endtask

    task automatic send_text(input string s, input bit close);
        expr_chars.delete();
        for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
        send_expr(close);
    endtask

    // no transaction in flight and nothing owed; then let the pipeline empty
    task automatic settle();
        char_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_config(input logic [7:0] first, input logic [7:0] second,
                                input logic [7:0] third, input logic [1:0] len,
                                input logic mode);
        write_reg(CFG_FIRST, first);
        write_reg(CFG_SECOND, second);
        write_reg(CFG_THIRD, third);
        write_reg(CFG_LENGTH, {6'd0, len});
        write_reg(CFG_LAST, {7'd0, mode});
        i_cfg_we <= 1'b0;
    endtask

    // operator characters: common ones, the steering characters but the backslash, the byte extremes, random bytes
    function automatic logic [7:0] pick_op_code();
        string pool;
        int    r;
        pool = "=+-<>&|!*a])\"([";
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        if (r == 2) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] noise_code();
        logic [7:0] special[8];
        special = '{CH_QUOTE, CH_BSLASH, CH_EQ, CH_POPEN, CH_PCLOSE, CH_SOPEN, CH_SCLOSE,
                    tracker.op_code[$urandom_range(0, 2)]};
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        return special[$urandom_range(0, 7)];
    endfunction

    // mostly nested expressions with operators inside and out, some plain noise
    function automatic void build_expr();
        logic [7:0] closers[$];
        int         n;
        int         cut;
        expr_chars.delete();
        if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 16)) expr_chars.push_back(noise_code());
            return;
        end
        n = $urandom_range(1, 10);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1: expr_chars.push_back(8'("a") + 8'($urandom_range(0, 25)));
                2, 3: begin
                    // whole operator most of the time, a prefix now and then
                    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 3;
                    for (int j = 0; j < tracker.op_size() && j < cut; j++)
                        expr_chars.push_back(tracker.op_code[j]);
                end
                4: begin
                    expr_chars.push_back(CH_POPEN);
                    closers.push_back(CH_PCLOSE);
                end
                5: begin
                    expr_chars.push_back(CH_SOPEN);
                    closers.push_back(CH_SCLOSE);
                end
                6: begin
                    if (closers.size() != 0) expr_chars.push_back(closers.pop_back());
                    else expr_chars.push_back(CH_PCLOSE);
                end
                7: begin
                    // quoted string, escapes inside
                    expr_chars.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(0, 3))
                            0: expr_chars.push_back(8'("x"));
                            1: begin
                                expr_chars.push_back(CH_BSLASH);
                                expr_chars.push_back(CH_QUOTE);
                            end
                            2: expr_chars.push_back(tracker.op_code[0]);
                            default: expr_chars.push_back(CH_BSLASH);
                        endcase
                    end
                    expr_chars.push_back(CH_QUOTE);
                end
                8: expr_chars.push_back(CH_EQ);
                default: expr_chars.push_back(noise_code());
            endcase
        end
        // leave an opener unclosed once in a while
        if ($urandom_range(0, 9) != 0)
            while (closers.size() != 0) expr_chars.push_back(closers.pop_back());
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 40;
            default: return 80;
        endcase
    endfunction

    initial begin
        tracker = new();
        random_items = 0;
        send_pause_pct = 0;
        take_pause_pct = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_FIRST;
        i_cfg_data <= 8'd0;
        char_ch.valid <= 1'b0;
        char_ch.data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset configuration looks for a lone '='
        send_pause_pct = 30;
        take_pause_pct = 30;
        send_text("a=b", 1);
        send_text("a==b", 1);        // '=' next to '=' is rejected
        send_text(")=", 1);          // stray close paren voids later matches
        send_text("\"\\\"", 1);      // escaped quote leaves the string open
        send_text("[", 1);           // unclosed bracket
        send_text("(x", 1);          // unclosed paren is fine
        send_text("=", 1);           // lone '=' pending at the end still counts

        // byte extremes, three-character operator, last match wins
        settle();
        apply_config(8'hFF, 8'h00, 8'hFF, 2'd3, 1'b1);
        expr_chars = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
        send_expr(1);

        // registers change in the middle of an expression; length zero acts as one
        settle();
        apply_config(8'("+"), 8'("+"), 8'h00, 2'd2, 1'b0);
        send_text("a+", 0);
        settle();
        apply_config(8'("+"), 8'("+"), 8'h00, 2'd0, 1'b0);
        send_text("b", 1);

        // saturation of the paren depth counter, no idling
        settle();
        apply_config(CH_EQ, 8'h00, 8'h00, 2'd1, 1'b0);
        send_pause_pct = 0;
        take_pause_pct = 0;
        expr_chars.delete();
        repeat (DEEP_NEST) expr_chars.push_back(CH_POPEN);
        repeat (255) expr_chars.push_back(CH_PCLOSE);
        expr_chars.push_back(CH_EQ);
        expr_chars.push_back(8'("b"));
        send_expr(1);

        // random phases: new registers and new idling pattern each time
        while (random_items < RANDOM_ITEMS) begin
            settle();
            apply_config(pick_op_code(), pick_op_code(), pick_op_code(),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            send_pause_pct = pick_pct();
            take_pause_pct = pick_pct();
            repeat ($urandom_range(1, 12)) begin
                build_expr();
                send_expr(1);
                random_items += expr_chars.size();
            end
        end

        // wait for the last results, bounded
        char_ch.valid <= 1'b0;
        for (int w = 0; w < END_WAIT_LIMIT && tracker.awaited_matches.size() != 0; w++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.awaited_matches.size() != 0)
            tracker.report("results never delivered", tracker.awaited_matches.size(), 0);
        if (tracker.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
